// ===== rtl/exp_golomb_code_decoder_unit_assert.svh =====
// Assertion macros used by the checker file of the decoder.
`ifndef EXP_GOLOMB_CODE_DECODER_UNIT_ASSERT_SVH
`define EXP_GOLOMB_CODE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define EGD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egd assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define EGD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("egd assertion failed");

`endif

// ===== rtl/egd_pkg.sv =====
// Shared types, codes and helpers of the Exp-Golomb decoder.
`default_nettype none
package egd_pkg;

  // Longest prefix of zeros that still starts a legal code.
  localparam logic [4:0] MAX_PREFIX_ZEROS = 5'd31;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    EGD_IDLE,
    EGD_BITS,
    EGD_FLUSH
  } egd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic last_bit;
    logic flush;
  } egd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic res;
    logic pend_valid;
    logic out_free;
  } egd_sts_t;

  // Signed mapping of a ue value: odd goes positive, even goes negative.
  function automatic logic [31:0] se_map(input logic [31:0] ue);
    logic [31:0] half;
    half = ue >> 1;
    if (ue[0]) begin
      se_map = half + 32'd1;
    end else begin
      se_map = 32'd0 - half;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/egd_ctrl.sv =====
// Controller of the Exp-Golomb decoder: byte intake, bit sequencing, flush.
`default_nettype none
module egd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire egd_pkg::egd_sts_t sts,
  output egd_pkg::egd_cmd_t     cmd
);

  egd_pkg::egd_state_t state_r, state_nxt;
  logic [2:0]          bit_cnt_r, bit_cnt_nxt;
  logic                step_ok;
  logic                flush_done;

  // State and bit counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= egd_pkg::EGD_IDLE;
      bit_cnt_r <= 3'd0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  // A bit may only advance when its result has somewhere to go.
  assign step_ok    = !(sts.res && sts.pend_valid && !sts.out_free);
  assign flush_done = !sts.pend_valid || sts.out_free;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    bit_cnt_nxt  = bit_cnt_r;
    cmd          = '0;
    cmd.last_bit = (bit_cnt_r == 3'd7);
    in_tready    = 1'b0;
    unique case (state_r)
      egd_pkg::EGD_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load    = 1'b1;
          bit_cnt_nxt = 3'd0;
          state_nxt   = egd_pkg::EGD_BITS;
        end
      end
      egd_pkg::EGD_BITS: begin
        if (step_ok) begin
          cmd.step = 1'b1;
          if (bit_cnt_r == 3'd7) begin
            state_nxt = egd_pkg::EGD_FLUSH;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
          end
        end
      end
      egd_pkg::EGD_FLUSH: begin
        cmd.flush = 1'b1;
        if (flush_done) begin
          in_tready = 1'b1;
          if (in_tvalid) begin
            cmd.load    = 1'b1;
            bit_cnt_nxt = 3'd0;
            state_nxt   = egd_pkg::EGD_BITS;
          end else begin
            state_nxt = egd_pkg::EGD_IDLE;
          end
        end
      end
      default: begin
        state_nxt = egd_pkg::EGD_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/egd_datapath.sv =====
// Datapath of the Exp-Golomb decoder: bit shifter, code state, result buffers.
`default_nettype none
module egd_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire egd_pkg::egd_cmd_t cmd,
  output egd_pkg::egd_sts_t      sts,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_end,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [63:0]            out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  // Byte being walked, MSB first.
  logic [7:0]  byte_r;
  logic        end_r;

  // Code state.
  logic        in_suffix_r, in_suffix_nxt;
  logic [4:0]  zero_cnt_r, zero_cnt_nxt;
  logic [30:0] suffix_r, suffix_nxt;
  logic [4:0]  suffix_left_r, suffix_left_nxt;

  // One result held back until we know whether it ends the byte.
  logic        pend_valid_r;
  logic [31:0] pend_ue_r;
  logic [1:0]  pend_st_r;

  // Output register.
  logic        out_valid_r;
  logic [31:0] out_ue_r;
  logic [31:0] out_se_r;
  logic [1:0]  out_st_r;
  logic        out_last_r;

  // Bit step results.
  logic        bit_in;
  logic        res;
  logic [31:0] res_ue;
  logic [1:0]  res_st;
  logic [30:0] suffix_shift;
  logic [4:0]  left_dec;
  logic [31:0] prefix_base;
  logic        out_free;
  logic        move_out;
  logic        move_last;

  assign bit_in       = byte_r[7];
  assign suffix_shift = {suffix_r[29:0], bit_in};
  assign left_dec     = suffix_left_r - 5'd1;
  assign prefix_base  = (32'd1 << zero_cnt_r) - 32'd1;
  assign out_free     = !out_valid_r || out_tready;

  // Decode of the current bit, followed by the end-of-buffer check.
  always_comb begin
    in_suffix_nxt   = in_suffix_r;
    zero_cnt_nxt    = zero_cnt_r;
    suffix_nxt      = suffix_r;
    suffix_left_nxt = suffix_left_r;
    res             = 1'b0;
    res_ue          = 32'd0;
    res_st          = egd_pkg::ST_OK;
    if (!in_suffix_r) begin
      if (!bit_in) begin
        if (zero_cnt_r >= egd_pkg::MAX_PREFIX_ZEROS) begin
          res          = 1'b1;
          res_st       = egd_pkg::ST_LONG;
          zero_cnt_nxt = 5'd0;
        end else begin
          zero_cnt_nxt = zero_cnt_r + 5'd1;
        end
      end else if (zero_cnt_r == 5'd0) begin
        res = 1'b1;
      end else begin
        in_suffix_nxt   = 1'b1;
        suffix_nxt      = 31'd0;
        suffix_left_nxt = zero_cnt_r;
      end
    end else begin
      if (left_dec == 5'd0) begin
        res             = 1'b1;
        res_ue          = prefix_base + {1'b0, suffix_shift};
        in_suffix_nxt   = 1'b0;
        zero_cnt_nxt    = 5'd0;
        suffix_nxt      = 31'd0;
        suffix_left_nxt = 5'd0;
      end else begin
        suffix_nxt      = suffix_shift;
        suffix_left_nxt = left_dec;
      end
    end
    // A code still open after the final byte of a buffer is truncated.
    if (cmd.last_bit && end_r && (in_suffix_nxt || zero_cnt_nxt != 5'd0)) begin
      res             = 1'b1;
      res_ue          = 32'd0;
      res_st          = egd_pkg::ST_TRUNC;
      in_suffix_nxt   = 1'b0;
      zero_cnt_nxt    = 5'd0;
      suffix_nxt      = 31'd0;
      suffix_left_nxt = 5'd0;
    end
  end

  // A new result pushes the held one out; the flush pushes it out as last.
  assign move_last = cmd.flush && pend_valid_r && out_free;
  assign move_out  = (cmd.step && res && pend_valid_r) || move_last;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_suffix_r   <= 1'b0;
      zero_cnt_r    <= 5'd0;
      suffix_r      <= 31'd0;
      suffix_left_r <= 5'd0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.step) begin
        in_suffix_r   <= in_suffix_nxt;
        zero_cnt_r    <= zero_cnt_nxt;
        suffix_r      <= suffix_nxt;
        suffix_left_r <= suffix_left_nxt;
      end
      if (cmd.step && res) begin
        pend_valid_r <= 1'b1;
      end else if (move_last) begin
        pend_valid_r <= 1'b0;
      end
      if (move_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_byte;
      end_r  <= in_end;
    end else if (cmd.step) begin
      byte_r <= {byte_r[6:0], 1'b0};
    end
    if (cmd.step && res) begin
      pend_ue_r <= res_ue;
      pend_st_r <= res_st;
    end
    if (move_out) begin
      out_ue_r   <= pend_ue_r;
      out_se_r   <= egd_pkg::se_map(pend_ue_r);
      out_st_r   <= pend_st_r;
      out_last_r <= move_last;
    end
  end

  assign sts.res        = res;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_se_r, out_ue_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/exp_golomb_code_decoder_unit.sv =====
// Order-0 Exp-Golomb decoder: takes one stream byte a beat, walks its bits MSB
// first and gives one beat per finished code with its ue value, its se value
// and a status (ok, truncated at buffer end, prefix too long). Codes may span
// bytes; a byte gives zero to eight result beats and the last of them carries
// tlast. The decoder handles one bit per clock while it is not stalled: the
// shifter walks the eight bits of the byte, then a flush step hands the held
// result to the output register and takes the next byte. A result that the
// output register cannot take yet stalls the bit walk and the flush.
`default_nettype none
module exp_golomb_code_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] stream_byte
  input  wire logic        in_tlast,   // buffer_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [31:0] unsigned_value, [63:32] signed_value
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic             out_tlast   // last_of_byte
);

  egd_pkg::egd_cmd_t cmd;
  egd_pkg::egd_sts_t sts;

  // Sequencer.
  egd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Bit decoder and result buffers.
  egd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (in_tdata),
    .in_end     (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== rtl/egd_checker.sv =====
// Port checker of the Exp-Golomb decoder and its bind to the top level.
`default_nettype none
`include "exp_golomb_code_decoder_unit_assert.svh"
module egd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // Only the three defined status codes ever leave the block.
  `EGD_ASSERT_IMPL(a_status_known, out_tvalid, out_tuser <= egd_pkg::ST_LONG)

  // Error beats carry zero in both values.
  `EGD_ASSERT_IMPL(a_error_zero, out_tvalid && out_tuser != egd_pkg::ST_OK, out_tdata == 64'd0)

  // The signed value is the se mapping of the unsigned one.
  `EGD_ASSERT_IMPL(a_se_map, out_tvalid, out_tdata[63:32] == egd_pkg::se_map(out_tdata[31:0]))

  // A stalled result beat holds.
  `EGD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind exp_golomb_code_decoder_unit egd_checker u_egd_checker (.*);
`default_nettype wire
